### sv/jswf_pkg.sv
// Shared types and constants of the weighted job ordering core.
package jswf_pkg;

	localparam int DUR_W   = 16;
	localparam int WGT_W   = 16;
	localparam int IDX_W   = 6;
	localparam int TIME_W  = 22;
	localparam int WC_W    = 38;
	localparam int TOTAL_W = 44;

	// One stored job; the list in memory is kept in run order
	typedef struct packed {
		logic [WGT_W-1:0] weight;
		logic [DUR_W-1:0] duration;
		logic [IDX_W-1:0] idx;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_EMIT,
		ST_DRAIN
	} state_t;

endpackage

### sv/job_sort_weighted_flow_core.sv
// Top level of the weighted job ordering core: insertion list in memory and result pipeline.
//
// Usage: present a job on duration/weight/is_last with start high; the request is taken
// at a rising edge where start is high and busy is low. Each taken job is inserted into a
// list kept in run order (highest weight first, then shorter duration, then earlier
// arrival). Insertion walks the list from its tail through the single memory read port:
// a read step and a compare/shift step per entry passed, plus a final read or compare
// step; a job into an empty list takes only the final read step. A job that arrives
// with MAX_JOBS jobs stored is dropped and flagged on every result of that run.
// A request with is_last high closes the set: after its insertion the list is read out
// one entry per cycle into a three-stage pipeline (completion time add, weight multiply,
// running total add) feeding the output registers. Results leave one per cycle;
// result_valid marks each for exactly one cycle and last_result marks the final one.
// The receiver cannot stall, so nothing is buffered beyond the output registers. busy
// falls in the cycle the last result is presented, and the job count and drop flag are
// cleared then for the next set.
// Reset (arst_n low) empties the list, clears the drop flag and the pipeline valids;
// memory contents are not cleared, as only entries below the job count are ever read.
module job_sort_weighted_flow_core #(
	parameter int MAX_JOBS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [jswf_pkg::DUR_W-1:0]     duration,
	input  logic [jswf_pkg::WGT_W-1:0]     weight,
	input  logic                           is_last,
	output logic                           result_valid,
	output logic [jswf_pkg::IDX_W-1:0]     job_index,
	output logic [jswf_pkg::DUR_W-1:0]     job_duration,
	output logic [jswf_pkg::WGT_W-1:0]     job_weight,
	output logic [jswf_pkg::TIME_W-1:0]    completion_time,
	output logic [jswf_pkg::WC_W-1:0]      weighted_completion,
	output logic [jswf_pkg::TOTAL_W-1:0]   running_total,
	output logic                           jobs_dropped,
	output logic                           last_result
);
	import jswf_pkg::*;

	localparam int AW = $clog2(MAX_JOBS);
	localparam int CW = $clog2(MAX_JOBS + 1);
	localparam logic [CW-1:0] CAP = CW'(MAX_JOBS);

	// Job list, in run order
	job_t mem [MAX_JOBS];
	job_t rdata_q;

	state_t state_q, state_d;

	logic [CW-1:0] count_q;     // jobs stored for the current set
	logic          overflow_q;  // a job of this set was dropped
	logic          last_q;      // the job being inserted closes the set
	job_t          new_q;       // job being inserted
	logic [AW-1:0] p_q;         // hole in the list the new job moves through
	logic [AW-1:0] e_q;         // readout address
	logic [AW-1:0] last_addr;

	// Memory port controls from the state machine
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	job_t          mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic          ins_done;
	logic          shift;
	logic          emit_rd;
	logic          run_end;
	logic          accept;
	logic          new_first;

	// Result pipeline
	logic               v_s1, v_s2, v_s3;
	logic               last_s1, last_s2, last_s3;
	job_t               ent_s2, ent_s3;
	logic [TIME_W-1:0]  t_s2, t_s3;
	logic [WC_W-1:0]    wc_s3;
	logic [TIME_W-1:0]  t_q;
	logic [TOTAL_W-1:0] total_q;
	logic [TIME_W-1:0]  t_sum;
	logic [TOTAL_W-1:0] total_sum;

	// Output registers
	logic               result_valid_q;
	job_t               res_ent_q;
	logic [TIME_W-1:0]  res_t_q;
	logic [WC_W-1:0]    res_wc_q;
	logic [TOTAL_W-1:0] res_total_q;
	logic               res_drop_q;
	logic               res_last_q;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign last_addr = AW'(count_q - CW'(1));

	// The new job always carries the highest index, so it passes a stored job
	// only on a strictly higher weight or an equal weight and shorter duration.
	assign new_first = (new_q.weight > rdata_q.weight) ||
		((new_q.weight == rdata_q.weight) && (new_q.duration < rdata_q.duration));

	// Next state and memory port control
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = p_q;
		mem_wdata = new_q;
		mem_raddr = e_q;
		ins_done  = 1'b0;
		shift     = 1'b0;
		emit_rd   = 1'b0;
		run_end   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (count_q < CAP) begin
						state_d = ST_INS_RD;
					end else if (is_last) begin
						// set full: drop this job but still run the stored ones
						state_d = ST_EMIT;
					end
				end
			end
			ST_INS_RD: begin
				mem_raddr = p_q - AW'(1);
				if (p_q == '0) begin
					// reached the head: place the new job here
					mem_we   = 1'b1;
					ins_done = 1'b1;
					state_d  = last_q ? ST_EMIT : ST_IDLE;
				end else begin
					state_d = ST_INS_CMP;
				end
			end
			ST_INS_CMP: begin
				mem_we = 1'b1;
				if (new_first) begin
					// move the stored job one place down and keep walking
					mem_wdata = rdata_q;
					shift     = 1'b1;
					state_d   = ST_INS_RD;
				end else begin
					ins_done = 1'b1;
					state_d  = last_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				emit_rd = 1'b1;
				if (e_q == last_addr) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (v_s3 && last_s3) begin
					run_end = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Job list memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	// Set bookkeeping and insertion pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
			last_q     <= 1'b0;
			p_q        <= '0;
			e_q        <= '0;
		end else begin
			if (accept) begin
				last_q <= is_last;
				p_q    <= AW'(count_q);
				if (count_q >= CAP) begin
					overflow_q <= 1'b1;
				end
			end
			if (shift) begin
				p_q <= p_q - AW'(1);
			end
			if (ins_done) begin
				count_q <= count_q + CW'(1);
			end
			if (emit_rd) begin
				e_q <= (e_q == last_addr) ? '0 : e_q + AW'(1);
			end
			if (run_end) begin
				count_q    <= '0;
				overflow_q <= 1'b0;
			end
		end
	end

	// Hold the arriving job while it is inserted
	always_ff @(posedge clk) begin
		if (accept) begin
			new_q.weight   <= weight;
			new_q.duration <= duration;
			new_q.idx      <= IDX_W'(count_q);
		end
	end

	// Result pipeline: stage 1 adds the duration, stage 2 multiplies, stage 3 sums
	assign t_sum     = t_q + TIME_W'(rdata_q.duration);
	assign total_sum = total_q + TOTAL_W'(wc_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			last_s1        <= 1'b0;
			last_s2        <= 1'b0;
			last_s3        <= 1'b0;
			t_q            <= '0;
			total_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			v_s1           <= emit_rd;
			last_s1        <= emit_rd && (e_q == last_addr);
			v_s2           <= v_s1;
			last_s2        <= last_s1;
			v_s3           <= v_s2;
			last_s3        <= last_s2;
			result_valid_q <= v_s3;
			if (run_end) begin
				// start the next set from time zero
				t_q     <= '0;
				total_q <= '0;
			end else begin
				if (v_s1) begin
					t_q <= t_sum;
				end
				if (v_s3) begin
					total_q <= total_sum;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			ent_s2 <= rdata_q;
			t_s2   <= t_sum;
		end
		if (v_s2) begin
			ent_s3 <= ent_s2;
			t_s3   <= t_s2;
			wc_s3  <= WC_W'(t_s2) * WC_W'(ent_s2.weight);
		end
		if (v_s3) begin
			res_ent_q   <= ent_s3;
			res_t_q     <= t_s3;
			res_wc_q    <= wc_s3;
			res_total_q <= total_sum;
			res_drop_q  <= overflow_q;
			res_last_q  <= last_s3;
		end
	end

	assign result_valid        = result_valid_q;
	assign job_index           = res_ent_q.idx;
	assign job_duration        = res_ent_q.duration;
	assign job_weight          = res_ent_q.weight;
	assign completion_time     = res_t_q;
	assign weighted_completion = res_wc_q;
	assign running_total       = res_total_q;
	assign jobs_dropped        = res_drop_q;
	assign last_result         = res_last_q;

`ifndef ASSERT_OFF
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP)
		else $error("job count above capacity");

	a_hole_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INS_RD || state_q == ST_INS_CMP) |-> (CW'(p_q) <= count_q))
		else $error("insertion pointer beyond stored jobs");

	a_result_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> ($past(state_q) == ST_EMIT || $past(state_q) == ST_DRAIN))
		else $error("result outside a readout run");

	a_set_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && res_last_q) |-> (count_q == '0 && !overflow_q))
		else $error("set not cleared after final result");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the weighted job ordering core, with its own schedule predictor.
module tb_top;
	import jswf_pkg::*;

	localparam int CAPACITY    = 64;
	localparam int RANDOM_JOBS = 220;
	localparam int DRAIN_LIMIT = 20000;

	// One emitted schedule line, as seen on the result ports
	typedef struct {
		logic [IDX_W-1:0]   idx;
		logic [DUR_W-1:0]   dur;
		logic [WGT_W-1:0]   wgt;
		logic [TIME_W-1:0]  ctime;
		logic [WC_W-1:0]    wc;
		logic [TOTAL_W-1:0] total;
		logic               dropped;
		logic               last;
	} sched_line_t;

	// Keeps the current job set in run order and the schedule lines still owed by the core
	class weighted_schedule_board;
		job_t        set_jobs[$];
		bit          overflow_seen;
		sched_line_t owed_lines[$];
		int          errors;

		// Heavier first, then shorter, then earlier arrival
		function bit runs_first(job_t a, job_t b);
			if (a.weight != b.weight)
				return a.weight > b.weight;
			if (a.duration != b.duration)
				return a.duration < b.duration;
			return a.idx < b.idx;
		endfunction

		// Note one accepted request; a closing request turns the set into owed lines
		function void take_job(logic [DUR_W-1:0] dur, logic [WGT_W-1:0] wgt, logic last);
			job_t            fresh;
			job_t            held;
			int              k;
			longint unsigned elapsed;
			longint unsigned wc;
			longint unsigned total;
			sched_line_t     line;
			if (set_jobs.size() < CAPACITY) begin
				fresh.weight   = wgt;
				fresh.duration = dur;
				fresh.idx      = IDX_W'(set_jobs.size());
				k = set_jobs.size();
				set_jobs.push_back(fresh);
				// sift the new job forward to its place in run order
				while (k > 0 && runs_first(set_jobs[k], set_jobs[k-1])) begin
					held          = set_jobs[k];
					set_jobs[k]   = set_jobs[k-1];
					set_jobs[k-1] = held;
					k--;
				end
			end else begin
				overflow_seen = 1'b1;
			end
			if (!last)
				return;
			elapsed = 0;
			total   = 0;
			foreach (set_jobs[i]) begin
				elapsed      += set_jobs[i].duration;
				wc            = elapsed * set_jobs[i].weight;
				total        += wc;
				line.idx      = set_jobs[i].idx;
				line.dur      = set_jobs[i].duration;
				line.wgt      = set_jobs[i].weight;
				line.ctime    = TIME_W'(elapsed);
				line.wc       = WC_W'(wc);
				line.total    = TOTAL_W'(total);
				line.dropped  = overflow_seen;
				line.last     = (i == set_jobs.size() - 1);
				owed_lines.push_back(line);
			end
			set_jobs.delete();
			overflow_seen = 1'b0;
		endfunction

		function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		// Check one presented result against the oldest owed line
		function void check_result(sched_line_t got);
			sched_line_t want;
			if (owed_lines.size() == 0) begin
				$error("result with nothing owed: job_index %0d", got.idx);
				errors++;
				return;
			end
			want = owed_lines.pop_front();
			cmp_field("job_index", 64'(want.idx), 64'(got.idx));
			cmp_field("job_duration", 64'(want.dur), 64'(got.dur));
			cmp_field("job_weight", 64'(want.wgt), 64'(got.wgt));
			cmp_field("completion_time", 64'(want.ctime), 64'(got.ctime));
			cmp_field("weighted_completion", 64'(want.wc), 64'(got.wc));
			cmp_field("running_total", 64'(want.total), 64'(got.total));
			cmp_field("jobs_dropped", 64'(want.dropped), 64'(got.dropped));
			cmp_field("last_result", 64'(want.last), 64'(got.last));
		endfunction
	endclass

	logic                clk     = 1'b0;
	logic                arst_n  = 1'b0;
	logic                start   = 1'b0;
	logic [DUR_W-1:0]    duration = '0;
	logic [WGT_W-1:0]    weight  = '0;
	logic                is_last = 1'b0;
	logic                busy;
	logic                result_valid;
	logic [IDX_W-1:0]    job_index;
	logic [DUR_W-1:0]    job_duration;
	logic [WGT_W-1:0]    job_weight;
	logic [TIME_W-1:0]   completion_time;
	logic [WC_W-1:0]     weighted_completion;
	logic [TOTAL_W-1:0]  running_total;
	logic                jobs_dropped;
	logic                last_result;

	weighted_schedule_board board = new;
	int jobs_sent;

	job_sort_weighted_flow_core #(
		.MAX_JOBS(CAPACITY)
	) u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.duration           (duration),
		.weight             (weight),
		.is_last            (is_last),
		.result_valid       (result_valid),
		.job_index          (job_index),
		.job_duration       (job_duration),
		.job_weight         (job_weight),
		.completion_time    (completion_time),
		.weighted_completion(weighted_completion),
		.running_total      (running_total),
		.jobs_dropped       (jobs_dropped),
		.last_result        (last_result)
	);

	always #5 clk = ~clk;

	// Take every strobed result at the edge that ends its cycle; the core cannot be held off
	always @(posedge clk) begin
		sched_line_t seen;
		if (arst_n && result_valid === 1'b1) begin
			seen.idx     = job_index;
			seen.dur     = job_duration;
			seen.wgt     = job_weight;
			seen.ctime   = completion_time;
			seen.wc      = weighted_completion;
			seen.total   = running_total;
			seen.dropped = jobs_dropped;
			seen.last    = last_result;
			board.check_result(seen);
		end
	end

	// Offer one request after gap idle cycles and hold it until the core takes it.
	// With no gap, start stays high straight on from the previous request.
	task automatic send_job(input logic [DUR_W-1:0] dur, input logic [WGT_W-1:0] wgt,
			input logic last, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		duration <= dur;
		weight   <= wgt;
		is_last  <= last;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.take_job(dur, wgt, last);
		jobs_sent++;
	endtask

	// Lean towards extremes and a narrow pool so that weight and duration ties are common
	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(0, 3));
			1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			2: return 16'($urandom_range(65532, 65535));
			3: return 16'($urandom_range(0, 7) * 16'h2000);
			default: return 16'($urandom());
		endcase
	endfunction

	// Send one set of n jobs, the last one closing it; some sets go back to back
	task automatic send_set(input int n);
		bit burst;
		burst = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < n; i++)
			send_job(pick_value(), pick_value(), i == n - 1, burst ? 0 : $urandom_range(0, 7));
	endtask

	initial begin
		int waited;
		int size;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-job sets at both extremes
		send_job(16'h0000, 16'h0000, 1'b1, 0);
		send_job(16'hFFFF, 16'hFFFF, 1'b1, 2);
		// weight ties broken by duration, full ties broken by arrival
		send_job(16'd5, 16'd7, 1'b0, 0);
		send_job(16'd3, 16'd7, 1'b0, 1);
		send_job(16'd5, 16'd7, 1'b0, 0);
		send_job(16'hFFFF, 16'h0000, 1'b0, 3);
		send_job(16'h0000, 16'hFFFF, 1'b0, 0);
		send_job(16'd3, 16'd7, 1'b1, 0);
		// zero weight throughout: order falls to duration alone
		send_job(16'd9, 16'd0, 1'b0, 0);
		send_job(16'd1, 16'd0, 1'b0, 0);
		send_job(16'd4, 16'd0, 1'b1, 4);
		// alternating bit patterns and the largest products
		send_job(16'hAAAA, 16'h5555, 1'b0, 0);
		send_job(16'h5555, 16'hAAAA, 1'b0, 7);
		send_job(16'hFFFF, 16'hFFFF, 1'b0, 0);
		send_job(16'hFFFF, 16'hFFFF, 1'b1, 0);

		// full set whose closing job is dropped, then mostly short sets, a few over capacity
		jobs_sent = 0;
		send_set(CAPACITY + 1);
		while (jobs_sent < RANDOM_JOBS) begin
			if ($urandom_range(0, 9) == 0)
				size = $urandom_range(CAPACITY - 4, CAPACITY + 4);
			else
				size = $urandom_range(1, 12);
			send_set(size);
		end
		start <= 1'b0;

		// drain what is owed, then watch a little longer for stray results
		waited = 0;
		while (board.owed_lines.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (12) @(posedge clk);
		if (board.owed_lines.size() != 0) begin
			$error("%0d expected results never arrived", board.owed_lines.size());
			board.errors++;
		end
		if (board.errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	// Hard stop well beyond the slowest correct run
	initial begin
		#10_000_000;
		$display("tb_top: errors");
		$finish;
	end

endmodule
